FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables it.
`define DDPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define DDPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DDPS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: src/ddps_pkg.sv
`default_nettype none

package ddps_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_DRIVE = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RATIO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 3'd4;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_L_RATIO,
    MUL_HALF_SCALE,
    MUL_KP_LO,
    MUL_KP_HI,
    MUL_KD_LO,
    MUL_KD_HI
  } mul_sel_e;

  // Accumulator operations for the PD sum.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef struct packed {
    logic     capture;
    logic     drive;
    logic     stop;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     half_ld;
    logic     err_ld;
    logic     dist_ld;
    logic     sum_ld;
    logic     load_out;
    logic     idle_out;
  } ddps_cmd_t;

  typedef struct packed {
    logic mode_straight;
  } ddps_status_t;

endpackage

`default_nettype wire

FILE: src/differential_drive_pd_sync_ramp_top.sv
`default_nettype none

// Two-wheel straight-line synchronizer. Each input transaction is a tick with
// both tachometer positions, a drive command or a stop command. A drive command
// stores the negated speed as the duty setpoint and enters straight mode; a stop
// command clears the ramp, setpoint, previous error and distance, captures the
// position baselines from its own position fields and returns to idle. Commands
// and the unused kind code give no result and leave the block ready. A tick in
// idle mode passes through state S_IDLT and returns zero duties with the held
// distance. A tick in straight mode returns PD-corrected left and right duties
// and the distance since the last stop; it occupies the block through states
// S_M1 to S_M7, S_SUM and S_FIN before the next transaction can be accepted,
// while one shared 17x34-bit multiplier forms the six partial products of the
// error, the distance and the two gain terms one after another. The result
// sits in an output register, so a waiting result does not block acceptance of
// the next transaction; only the final step of the following tick waits for it
// to be taken. Configuration writes are always ready and must only be issued
// while the block is idle.
module differential_drive_pd_sync_ramp_top #(
  parameter int unsigned DUTY_LIMIT    = 100,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  // Item input channel.
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      kind_i,
  input  wire logic signed [7:0]               speed_command_i,
  input  wire logic signed [31:0]              left_position_i,
  input  wire logic signed [31:0]              right_position_i,

  // Result output channel.
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [7:0]                    left_duty_o,
  output logic signed [7:0]                    right_duty_o,
  output logic                                 drive_active_o,
  output logic signed [31:0]                   distance_o,

  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ddps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ddps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ddps_pkg::ddps_cmd_t    cmd;
  ddps_pkg::ddps_status_t status;

  // Register writes complete in the cycle they are presented.
  assign cfg_ready_o = 1'b1;

  // The controller sequences the multiplier steps and owns both handshakes.
  ddps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // The datapath holds configuration, motion state and the result register.
  ddps_dp #(
    .DUTY_LIMIT    (DUTY_LIMIT),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .speed_command_i  (speed_command_i),
    .left_position_i  (left_position_i),
    .right_position_i (right_position_i),
    .left_duty_o      (left_duty_o),
    .right_duty_o     (right_duty_o),
    .drive_active_o   (drive_active_o),
    .distance_o       (distance_o)
  );

endmodule

`default_nettype wire

FILE: src/ddps_ctrl.sv
`default_nettype none

module ddps_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [1:0]            kind_i,
  input  wire logic                  out_ready_i,
  input  wire ddps_pkg::ddps_status_t status_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  output ddps_pkg::ddps_cmd_t        cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_M4   = 4'd4;
  localparam logic [3:0] S_M5   = 4'd5;
  localparam logic [3:0] S_M6   = 4'd6;
  localparam logic [3:0] S_M7   = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_IDLT = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = ddps_pkg::MUL_L_RATIO;
    cmd_o.acc_op   = ddps_pkg::ACC_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            ddps_pkg::KIND_TICK: begin
              cmd_o.capture = 1'b1;
              state_d = status_i.mode_straight ? S_M1 : S_IDLT;
            end
            ddps_pkg::KIND_DRIVE: cmd_o.drive = 1'b1;
            ddps_pkg::KIND_STOP:  cmd_o.stop  = 1'b1;
            default: ;
          endcase
        end
      end
      S_M1: begin
        cmd_o.mul_sel = ddps_pkg::MUL_L_RATIO;
        cmd_o.half_ld = 1'b1;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o.mul_sel = ddps_pkg::MUL_HALF_SCALE;
        cmd_o.err_ld  = 1'b1;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o.mul_sel = ddps_pkg::MUL_KP_LO;
        cmd_o.dist_ld = 1'b1;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.mul_sel = ddps_pkg::MUL_KP_HI;
        cmd_o.acc_op  = ddps_pkg::ACC_LOAD;
        state_d = S_M5;
      end
      S_M5: begin
        cmd_o.mul_sel = ddps_pkg::MUL_KD_LO;
        cmd_o.acc_op  = ddps_pkg::ACC_ADD_HI;
        state_d = S_M6;
      end
      S_M6: begin
        cmd_o.mul_sel = ddps_pkg::MUL_KD_HI;
        cmd_o.acc_op  = ddps_pkg::ACC_ADD;
        state_d = S_M7;
      end
      S_M7: begin
        cmd_o.acc_op = ddps_pkg::ACC_ADD_HI;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_ld = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_IDLT: begin
        if (out_free) begin
          cmd_o.idle_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out || cmd_o.idle_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/ddps_dp.sv
`default_nettype none

module ddps_dp #(
  parameter int unsigned DUTY_LIMIT    = 100,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ddps_pkg::ddps_cmd_t                cmd_i,
  output ddps_pkg::ddps_status_t                  status_o,
  input  wire logic                               cfg_valid_i,
  input  wire logic [ddps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ddps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic signed [7:0]                  speed_command_i,
  input  wire logic signed [31:0]                 left_position_i,
  input  wire logic signed [31:0]                 right_position_i,
  output logic signed [7:0]                       left_duty_o,
  output logic signed [7:0]                       right_duty_o,
  output logic                                    drive_active_o,
  output logic signed [31:0]                      distance_o
);

  localparam int unsigned P = POSITION_BITS;

  localparam logic signed [51:0] ErrMax  = (52'sd1 <<< 47) - 52'sd1;
  localparam logic signed [51:0] ErrMin  = -(52'sd1 <<< 47);
  localparam logic signed [48:0] DiffMax = 49'sd1 <<< 40;
  localparam logic signed [48:0] DiffMin = -(49'sd1 <<< 40);
  localparam logic signed [50:0] DistMax = (51'sd1 <<< 31) - 51'sd1;
  localparam logic signed [50:0] DistMin = -(51'sd1 <<< 31);
  localparam logic signed [66:0] LimQ    = $signed(67'(DUTY_LIMIT) <<< 22);
  localparam logic signed [66:0] LimQNeg = -LimQ;

  // Configuration registers.
  logic signed [15:0] kp_q, kd_q;
  logic        [15:0] ratio_q, scale_q;
  logic        [14:0] step_q;

  // Motion state.
  logic               mode_q;
  logic signed [7:0]  sp_q;
  logic signed [15:0] ramp_q;
  logic signed [47:0] prev_q;
  logic [P-1:0]       lbase_q, rbase_q;
  logic signed [31:0] held_q;

  // Per-tick working registers.
  logic signed [P-1:0] l_q, r_q;
  logic signed [P:0]   nhalf_q;
  logic signed [50:0]  prod_q;
  logic signed [47:0]  err_q;
  logic signed [41:0]  diff_q;
  logic signed [31:0]  dist_q;
  logic signed [65:0]  acc_q;
  logic signed [66:0]  sum_l_q, sum_r_q;

  // Result register.
  logic signed [7:0]  left_q, right_q;
  logic               active_q;
  logic signed [31:0] dist_out_q;

  logic signed [16:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [P:0]  pos_sum, pos_adj, half;
  logic signed [51:0] err_full;
  logic signed [48:0] diff_full;
  logic signed [66:0] base;
  logic signed [17:0] target, step_s, lo_lim, hi_lim, ramp1, ramp2;
  logic signed [15:0] ramp_next;
  logic signed [9:0]  duty_l, duty_r;

  function automatic logic signed [9:0] duty_f(input logic signed [66:0] v);
    logic signed [66:0] c;
    logic signed [31:0] t;
    begin
      if (v > LimQ) begin
        c = LimQ;
      end else if (v < LimQNeg) begin
        c = LimQNeg;
      end else begin
        c = v;
      end
      t = 32'(c);
      if (t < 0) begin
        t = t + 32'sd4194303;
      end
      duty_f = 10'(t >>> 22);
    end
  endfunction

  assign status_o.mode_straight = mode_q;

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd_i.mul_sel)
      ddps_pkg::MUL_L_RATIO: begin
        mul_a = $signed({1'b0, ratio_q});
        mul_b = 34'(l_q);
      end
      ddps_pkg::MUL_HALF_SCALE: begin
        mul_a = $signed({1'b0, scale_q});
        mul_b = 34'(nhalf_q);
      end
      ddps_pkg::MUL_KP_LO: begin
        mul_a = 17'(kp_q);
        mul_b = $signed({10'b0, err_q[23:0]});
      end
      ddps_pkg::MUL_KP_HI: begin
        mul_a = 17'(kp_q);
        mul_b = 34'($signed(err_q[47:24]));
      end
      ddps_pkg::MUL_KD_LO: begin
        mul_a = 17'(kd_q);
        mul_b = $signed({10'b0, diff_q[23:0]});
      end
      ddps_pkg::MUL_KD_HI: begin
        mul_a = 17'(kd_q);
        mul_b = 34'($signed(diff_q[41:24]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Half-sum of the positions, truncated toward zero.
  assign pos_sum = (P+1)'(l_q) + (P+1)'(r_q);
  assign pos_adj = pos_sum + $signed({{P{1'b0}}, pos_sum[P]});
  assign half    = pos_adj >>> 1;

  assign err_full  = 52'(prod_q) - (52'(r_q) <<< 14);
  assign diff_full = 49'(err_q) - 49'(prev_q);
  assign base      = 67'(ramp_q) <<< 14;

  // Ramp toward the setpoint.
  assign target = 18'(sp_q) <<< 8;
  assign step_s = $signed({3'b0, step_q});
  assign lo_lim = target - step_s;
  assign hi_lim = target + step_s;
  assign ramp1  = (18'(ramp_q) < lo_lim) ? 18'(ramp_q) + step_s : 18'(ramp_q);
  assign ramp2  = (ramp1 > hi_lim) ? ramp1 - step_s : ramp1;
  assign ramp_next = (ramp2 > 18'sd32767)  ? 16'sh7FFF :
                     (ramp2 < -18'sd32768) ? 16'sh8000 : 16'(ramp2);

  assign duty_l = duty_f(sum_l_q);
  assign duty_r = duty_f(sum_r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= 16'sd256;
      kd_q    <= 16'sd0;
      ratio_q <= 16'd16384;
      step_q  <= 15'd256;
      scale_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ddps_pkg::CFG_PROP_GAIN:      kp_q    <= $signed(cfg_data_i);
        ddps_pkg::CFG_DERIV_GAIN:     kd_q    <= $signed(cfg_data_i);
        ddps_pkg::CFG_WHEEL_RATIO:    ratio_q <= cfg_data_i;
        ddps_pkg::CFG_RAMP_STEP:      step_q  <= cfg_data_i[14:0];
        ddps_pkg::CFG_DISTANCE_SCALE: scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      sp_q    <= '0;
      ramp_q  <= '0;
      prev_q  <= '0;
      lbase_q <= '0;
      rbase_q <= '0;
      held_q  <= '0;
    end else begin
      if (cmd_i.drive) begin
        sp_q   <= (speed_command_i == -8'sd128) ? 8'sd127 : -speed_command_i;
        mode_q <= 1'b1;
      end
      if (cmd_i.stop) begin
        sp_q    <= '0;
        ramp_q  <= '0;
        prev_q  <= '0;
        held_q  <= '0;
        lbase_q <= left_position_i[P-1:0];
        rbase_q <= right_position_i[P-1:0];
        mode_q  <= 1'b0;
      end
      if (cmd_i.load_out) begin
        prev_q <= err_q;
        held_q <= dist_q;
        ramp_q <= ramp_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      l_q <= $signed(left_position_i[P-1:0] - lbase_q);
      r_q <= $signed(right_position_i[P-1:0] - rbase_q);
    end
    if (cmd_i.half_ld) begin
      nhalf_q <= -half;
    end
    if (cmd_i.err_ld) begin
      if (err_full > ErrMax) begin
        err_q <= 48'(ErrMax);
      end else if (err_full < ErrMin) begin
        err_q <= 48'(ErrMin);
      end else begin
        err_q <= 48'(err_full);
      end
    end
    if (cmd_i.dist_ld) begin
      if (prod_q > DistMax) begin
        dist_q <= 32'(DistMax);
      end else if (prod_q < DistMin) begin
        dist_q <= 32'(DistMin);
      end else begin
        dist_q <= 32'(prod_q);
      end
      if (diff_full > DiffMax) begin
        diff_q <= 42'(DiffMax);
      end else if (diff_full < DiffMin) begin
        diff_q <= 42'(DiffMin);
      end else begin
        diff_q <= 42'(diff_full);
      end
    end
    case (cmd_i.acc_op)
      ddps_pkg::ACC_LOAD:   acc_q <= 66'(prod_q);
      ddps_pkg::ACC_ADD:    acc_q <= acc_q + 66'(prod_q);
      ddps_pkg::ACC_ADD_HI: acc_q <= acc_q + (66'(prod_q) <<< 24);
      default: ;
    endcase
    if (cmd_i.sum_ld) begin
      sum_l_q <= base - 67'(acc_q);
      sum_r_q <= base + 67'(acc_q);
    end
    if (cmd_i.load_out) begin
      left_q     <= duty_l[7:0];
      right_q    <= duty_r[7:0];
      active_q   <= 1'b1;
      dist_out_q <= dist_q;
    end else if (cmd_i.idle_out) begin
      left_q     <= '0;
      right_q    <= '0;
      active_q   <= 1'b0;
      dist_out_q <= held_q;
    end
  end

  assign left_duty_o    = left_q;
  assign right_duty_o   = right_q;
  assign drive_active_o = active_q;
  assign distance_o     = dist_out_q;

endmodule

`default_nettype wire

FILE: src/ddps_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ddps_checker #(
  parameter int unsigned DUTY_LIMIT = 100
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        kind_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic signed [7:0] left_duty_o,
  input wire logic signed [7:0] right_duty_o,
  input wire logic              drive_active_o
);

  localparam int Lim = (DUTY_LIMIT > 127) ? 128 : int'(DUTY_LIMIT);

  logic in_acc;
  logic out_hold;
  logic duty_bad;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_hold = out_valid_o && !out_ready_i;
  assign duty_bad = (left_duty_o < -Lim) || (left_duty_o > Lim) ||
                    (right_duty_o < -Lim) || (right_duty_o > Lim);

  // A pending result keeps its duties until it is taken.
  `DDPS_ASSERT(a_out_hold, clk_i, rst_ni, out_hold |=> out_valid_o && $stable(left_duty_o) && $stable(right_duty_o), "result changed while stalled")

  // An idle result never drives the motors.
  `DDPS_ASSERT_NEVER(a_idle_zero, clk_i, rst_ni, out_valid_o && !drive_active_o && (left_duty_o != 8'sd0 || right_duty_o != 8'sd0), "idle result with nonzero duty")

  // Duties stay within the limit.
  `DDPS_ASSERT_NEVER(a_duty_range, clk_i, rst_ni, out_valid_o && duty_bad, "duty beyond limit")

  // A tick occupies the block for at least the following cycle.
  `DDPS_ASSERT(a_tick_busy, clk_i, rst_ni, (in_acc && kind_i == ddps_pkg::KIND_TICK) |=> !in_ready_o, "ready right after a tick")

  // Commands produce no result.
  `DDPS_ASSERT(a_cmd_silent, clk_i, rst_ni, (in_acc && kind_i != ddps_pkg::KIND_TICK && !out_valid_o) |=> !out_valid_o, "result after a command")

endmodule

bind differential_drive_pd_sync_ramp_top ddps_checker #(
  .DUTY_LIMIT (DUTY_LIMIT)
) u_ddps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .kind_i         (kind_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .left_duty_o    (left_duty_o),
  .right_duty_o   (right_duty_o),
  .drive_active_o (drive_active_o)
);

`default_nettype wire
